FILE: rtl/gmp_pkg.sv
package gmp_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 32;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int DIM_W    = 6;
	localparam int COST_W   = 16;
	localparam int SUM_W    = 23;
	localparam int TOTAL_W  = 22;
	localparam int LEN_W    = 6;
	localparam int PATH_W   = MAX_ROWS + MAX_COLS - 2;
	localparam int CF_AW    = ROW_W + COL_W;
	localparam int DATA_W   = 24;

	// Configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// Result kinds carried in tuser
	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_MOVE  = 1'b1;

	// Move codes
	localparam logic MOVE_RIGHT = 1'b0;
	localparam logic MOVE_DOWN  = 1'b1;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [4:0] {
		ST_RUN     = 5'b00001,
		ST_TOTAL   = 5'b00010,
		ST_TR_READ = 5'b00100,
		ST_TR_STEP = 5'b01000,
		ST_EMIT    = 5'b10000
	} state_t;

	// Turn a size register into the index of the last row or column in use
	function automatic logic [ROW_W-1:0] last_row(input logic [DIM_W-1:0] v);
		logic [ROW_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (v > DIM_W'(MAX_ROWS))
			r = ROW_W'(MAX_ROWS - 1);
		else
			r = ROW_W'(v - DIM_W'(1));
		return r;
	endfunction

	function automatic logic [COL_W-1:0] last_col(input logic [DIM_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (v > DIM_W'(MAX_COLS))
			r = COL_W'(MAX_COLS - 1);
		else
			r = COL_W'(v - DIM_W'(1));
		return r;
	endfunction

endpackage

FILE: rtl/grid_max_path_with_traceback_top.sv
// Grid max path sum with traceback.
// Throughput: one cell per cycle within a grid; each cell is summed in the cycle after acceptance
// from the row-sum read issued at acceptance, forwarded in one-column grids. After the last cell
// the input stalls until the last result of the run is loaded into the output register.
// The total is held in total_q and loaded out in the TOTAL state; each move is a direction read,
// then decide; moves drain at one per cycle while m_tready is high. Reset: 1x1 grid, top-left.
module grid_max_path_with_traceback_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] cost
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [21:0] total, [22] move, [23] zero
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast
);

	// Configuration and position
	logic [gmp_pkg::DIM_W-1:0] rows_q, cols_q;
	logic [gmp_pkg::ROW_W-1:0] rmax, row_pos_q;
	logic [gmp_pkg::COL_W-1:0] cmax, col_pos_q;
	logic [gmp_pkg::LEN_W-1:0] len;

	// Cell pipeline stage
	logic                       s1_valid;
	logic [gmp_pkg::ROW_W-1:0]  s1_row;
	logic [gmp_pkg::COL_W-1:0]  s1_col;
	logic                       s1_last;
	logic signed [gmp_pkg::COST_W-1:0] s1_cost;
	logic                       fwd_s1;
	gmp_pkg::sum_t              fwd_val_s1, rd_row_s1;
	gmp_pkg::sum_t              left_q, total_q;

	// Memories
	gmp_pkg::sum_t row_best_mem [gmp_pkg::MAX_COLS];
	logic          came_from_mem [gmp_pkg::MAX_ROWS * gmp_pkg::MAX_COLS];
	logic          cf_rd_q;

	// Traceback and output
	gmp_pkg::state_t           state_q;
	logic [gmp_pkg::ROW_W-1:0] i_q;
	logic [gmp_pkg::COL_W-1:0] j_q;
	logic [gmp_pkg::LEN_W-1:0] k_q, e_q;
	logic [gmp_pkg::PATH_W-1:0] path_q;
	logic                      out_valid_q, out_kind_q, out_move_q, out_last_q;
	logic [gmp_pkg::TOTAL_W-1:0] out_total_q;

	logic          accept, out_free, dir, step_d;
	gmp_pkg::sum_t cost_x, above, best;

	assign rmax     = gmp_pkg::last_row(rows_q);
	assign cmax     = gmp_pkg::last_col(cols_q);
	assign len      = gmp_pkg::LEN_W'(rmax) + gmp_pkg::LEN_W'(cmax);
	assign s_tready = (state_q == gmp_pkg::ST_RUN) && !(s1_valid && s1_last);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Sum the cell: better of above and left (edges take the only one), down wins a tie
	assign cost_x = {{(gmp_pkg::SUM_W - gmp_pkg::COST_W){s1_cost[gmp_pkg::COST_W-1]}}, s1_cost};
	assign above  = fwd_s1 ? fwd_val_s1 : rd_row_s1;

	always_comb begin
		priority if (s1_row == '0 && s1_col == '0) begin
			best = cost_x;
			dir  = gmp_pkg::MOVE_RIGHT;
		end else if (s1_row == '0) begin
			best = left_q + cost_x;
			dir  = gmp_pkg::MOVE_RIGHT;
		end else if (s1_col == '0 || above >= left_q) begin
			best = above + cost_x;
			dir  = gmp_pkg::MOVE_DOWN;
		end else begin
			best = left_q + cost_x;
			dir  = gmp_pkg::MOVE_RIGHT;
		end
	end

	// Traceback decision; edges of the grid force the move
	always_comb begin
		priority if (i_q == '0)
			step_d = gmp_pkg::MOVE_RIGHT;
		else if (j_q == '0)
			step_d = gmp_pkg::MOVE_DOWN;
		else
			step_d = cf_rd_q;
	end

	// Row sum memory: read at acceptance, write back from the stage
	always_ff @(posedge clk) begin
		if (accept)
			rd_row_s1 <= row_best_mem[col_pos_q];
		if (s1_valid)
			row_best_mem[s1_col] <= best;
	end

	// Direction memory: write per cell, read for traceback
	always_ff @(posedge clk) begin
		cf_rd_q <= came_from_mem[{i_q, j_q}];
		if (s1_valid)
			came_from_mem[{s1_row, s1_col}] <= dir;
	end

	// Stage payload and forwarding
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_row     <= row_pos_q;
			s1_col     <= col_pos_q;
			s1_last    <= (row_pos_q == rmax) && (col_pos_q == cmax);
			s1_cost    <= s_tdata;
			fwd_s1     <= s1_valid && (s1_col == col_pos_q);
			fwd_val_s1 <= best;
		end
		if (s1_valid)
			total_q <= best;
	end

	// Control: configuration, positions, traceback sequencer, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= gmp_pkg::DIM_W'(1);
			cols_q      <= gmp_pkg::DIM_W'(1);
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			left_q      <= '0;
			s1_valid    <= 1'b0;
			state_q     <= gmp_pkg::ST_RUN;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			path_q      <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_total_q <= '0;
			out_move_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			s1_valid <= accept;

			// Restart the run on a register write, else advance on each accepted cell
			if (cfg_we) begin
				unique case (cfg_index)
					gmp_pkg::REG_ROWS: rows_q <= cfg_data;
					gmp_pkg::REG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
				row_pos_q <= '0;
				col_pos_q <= '0;
				left_q    <= '0;
			end else begin
				if (s1_valid)
					left_q <= best;
				if (accept) begin
					if (col_pos_q == cmax) begin
						col_pos_q <= '0;
						row_pos_q <= (row_pos_q == rmax) ? '0
							: row_pos_q + gmp_pkg::ROW_W'(1);
					end else begin
						col_pos_q <= col_pos_q + gmp_pkg::COL_W'(1);
					end
				end
			end

			// Load the output register, or drop it once taken
			if ((state_q == gmp_pkg::ST_TOTAL || state_q == gmp_pkg::ST_EMIT) && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				gmp_pkg::ST_RUN: begin
					if (s1_valid && s1_last)
						state_q <= gmp_pkg::ST_TOTAL;
				end
				gmp_pkg::ST_TOTAL: begin
					if (out_free) begin
						out_kind_q  <= gmp_pkg::KIND_TOTAL;
						out_total_q <= total_q[gmp_pkg::TOTAL_W-1:0];
						out_move_q  <= 1'b0;
						out_last_q  <= (len == '0);
						i_q         <= rmax;
						j_q         <= cmax;
						k_q         <= len;
						state_q     <= (len == '0) ? gmp_pkg::ST_RUN : gmp_pkg::ST_TR_READ;
					end
				end
				gmp_pkg::ST_TR_READ: begin
					state_q <= gmp_pkg::ST_TR_STEP;
				end
				gmp_pkg::ST_TR_STEP: begin
					path_q[k_q - gmp_pkg::LEN_W'(1)] <= step_d;
					if (step_d == gmp_pkg::MOVE_DOWN)
						i_q <= i_q - gmp_pkg::ROW_W'(1);
					else
						j_q <= j_q - gmp_pkg::COL_W'(1);
					k_q <= k_q - gmp_pkg::LEN_W'(1);
					e_q <= '0;
					state_q <= (k_q == gmp_pkg::LEN_W'(1)) ? gmp_pkg::ST_EMIT
						: gmp_pkg::ST_TR_READ;
				end
				gmp_pkg::ST_EMIT: begin
					if (out_free) begin
						out_kind_q  <= gmp_pkg::KIND_MOVE;
						out_total_q <= '0;
						out_move_q  <= path_q[e_q];
						out_last_q  <= (e_q == len - gmp_pkg::LEN_W'(1));
						e_q         <= e_q + gmp_pkg::LEN_W'(1);
						if (e_q == len - gmp_pkg::LEN_W'(1))
							state_q <= gmp_pkg::ST_RUN;
					end
				end
				default: state_q <= gmp_pkg::ST_RUN;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_move_q, out_total_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// Forwarding only occurs when consecutive cells share a column
	a_fwd_one_col: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && fwd_s1) |-> (cmax == '0))
		else $error("row sum forwarding outside a one-column grid");

	// Remaining moves equal the distance back to the start at every traceback step
	a_trace_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gmp_pkg::ST_TR_STEP) |->
		(gmp_pkg::LEN_W'(i_q) + gmp_pkg::LEN_W'(j_q) == k_q))
		else $error("traceback position and move count disagree");

	// The total goes out before any move
	a_total_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gmp_pkg::ST_TOTAL && out_free) |=>
		(m_tvalid && m_tuser == gmp_pkg::KIND_TOTAL))
		else $error("total result not loaded");

	// No cell is taken while a run finishes
	a_no_accept_trace: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gmp_pkg::ST_RUN) |-> !accept)
		else $error("cell accepted during traceback");

endmodule
